// ----- rtl/cll_pkg.sv -----
`default_nettype none
package cll_pkg;

   localparam int SLOTS       = 16;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int LINK_W      = SLOT_W + 1;
   localparam int MAX_RESULTS = 16;
   localparam int NRES_W      = $clog2(MAX_RESULTS);

   localparam logic [1:0] MODE_LIST   = 2'd0;
   localparam logic [1:0] MODE_APPEND = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   localparam logic [1:0] SRC_ZERO = 2'd0;
   localparam logic [1:0] SRC_CUR  = 2'd1;
   localparam logic [1:0] SRC_SCAN = 2'd2;

   typedef struct packed {
      logic        [1:0]  mode;
      logic signed [15:0] value;
   } cll_req_type;

   typedef struct packed {
      logic signed [15:0] value_out;
      logic        [3:0]  slot;
      logic        [1:0]  status;
      logic               last;
   } cll_rsp_type;

   typedef struct packed {
      logic       latch_req;
      logic       start_list;
      logic       start_scan;
      logic       start_del;
      logic       scan_step;
      logic       rd_en;
      logic       list_emit;
      logic       app_node;
      logic       app_link;
      logic       del_step;
      logic       del_unlink;
      logic       set_result;
      logic [1:0] res_status;
      logic [1:0] res_slot_src;
      logic       emit_pending;
   } cll_cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       head_valid;
      logic       scan_free;
      logic       scan_done;
      logic       rd_match;
      logic       rd_end;
      logic       list_last;
      logic       out_free;
   } cll_sts_type;

endpackage
`default_nettype wire

// ----- rtl/cll_ram.sv -----
`default_nettype none
module cll_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/cll_ctrl.sv -----
`default_nettype none
module cll_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire cll_pkg::cll_sts_type sts,
   output logic                      req_stall,
   output cll_pkg::cll_cmd_type      cmd
);
   import cll_pkg::*;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DECODE   = 4'd1;
   localparam logic [3:0] ST_SCAN     = 4'd2;
   localparam logic [3:0] ST_APP_NODE = 4'd3;
   localparam logic [3:0] ST_APP_LINK = 4'd4;
   localparam logic [3:0] ST_LIST_RD  = 4'd5;
   localparam logic [3:0] ST_LIST_OUT = 4'd6;
   localparam logic [3:0] ST_DEL_RD   = 4'd7;
   localparam logic [3:0] ST_DEL_CHK  = 4'd8;
   localparam logic [3:0] ST_EMIT     = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (sts.mode)
               MODE_LIST: begin
                  if (sts.head_valid) begin
                     cmd.start_list = 1'b1;
                     state_in       = ST_LIST_RD;
                  end else begin
                     cmd.set_result   = 1'b1;
                     cmd.res_status   = STATUS_EMPTY;
                     cmd.res_slot_src = SRC_ZERO;
                     state_in         = ST_EMIT;
                  end
               end
               MODE_APPEND: begin
                  cmd.start_scan = 1'b1;
                  state_in       = ST_SCAN;
               end
               MODE_DELETE: begin
                  if (sts.head_valid) begin
                     cmd.start_del = 1'b1;
                     state_in      = ST_DEL_RD;
                  end else begin
                     cmd.set_result   = 1'b1;
                     cmd.res_status   = STATUS_EMPTY;
                     cmd.res_slot_src = SRC_ZERO;
                     state_in         = ST_EMIT;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SCAN: begin
            if (sts.scan_free) begin
               state_in = ST_APP_NODE;
            end else if (sts.scan_done) begin
               cmd.set_result   = 1'b1;
               cmd.res_status   = STATUS_FULL;
               cmd.res_slot_src = SRC_ZERO;
               state_in         = ST_EMIT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_APP_NODE: begin
            cmd.app_node = 1'b1;
            if (sts.head_valid) begin
               state_in = ST_APP_LINK;
            end else begin
               cmd.set_result   = 1'b1;
               cmd.res_status   = STATUS_OK;
               cmd.res_slot_src = SRC_SCAN;
               state_in         = ST_EMIT;
            end
         end
         ST_APP_LINK: begin
            cmd.app_link     = 1'b1;
            cmd.set_result   = 1'b1;
            cmd.res_status   = STATUS_OK;
            cmd.res_slot_src = SRC_SCAN;
            state_in         = ST_EMIT;
         end
         ST_LIST_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_LIST_OUT;
         end
         ST_LIST_OUT: begin
            if (sts.out_free) begin
               cmd.list_emit = 1'b1;
               state_in      = sts.list_last ? ST_IDLE : ST_LIST_RD;
            end
         end
         ST_DEL_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_DEL_CHK;
         end
         ST_DEL_CHK: begin
            if (sts.rd_match) begin
               cmd.del_unlink   = 1'b1;
               cmd.set_result   = 1'b1;
               cmd.res_status   = STATUS_OK;
               cmd.res_slot_src = SRC_CUR;
               state_in         = ST_EMIT;
            end else if (sts.rd_end) begin
               cmd.set_result   = 1'b1;
               cmd.res_status   = STATUS_NOT_FOUND;
               cmd.res_slot_src = SRC_ZERO;
               state_in         = ST_EMIT;
            end else begin
               cmd.del_step = 1'b1;
               state_in     = ST_DEL_RD;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_pending = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/cll_datapath.sv -----
`default_nettype none
module cll_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cll_pkg::cll_req_type req_data,
   input  wire logic                 rsp_stall,
   input  wire cll_pkg::cll_cmd_type cmd,
   output cll_pkg::cll_sts_type      sts,
   output logic                      rsp_valid,
   output cll_pkg::cll_rsp_type      rsp_data
);
   import cll_pkg::*;

   cll_req_type        req_ff,         req_in;
   logic [SLOT_W-1:0]  cur_ff,         cur_in;
   logic [SLOT_W-1:0]  prev_ff,        prev_in;
   logic               prev_valid_ff,  prev_valid_in;
   logic [SLOT_W-1:0]  cnt_ff,         cnt_in;
   logic [NRES_W-1:0]  nres_ff,        nres_in;
   logic [SLOT_W-1:0]  head_ff,        head_in;
   logic               head_valid_ff,  head_valid_in;
   logic [SLOT_W-1:0]  tail_ff,        tail_in;
   logic [SLOTS-1:0]   used_ff,        used_in;
   logic signed [15:0] pend_value_ff,  pend_value_in;
   logic [SLOT_W-1:0]  pend_slot_ff,   pend_slot_in;
   logic [1:0]         pend_status_ff, pend_status_in;
   cll_rsp_type        rsp_ff,         rsp_in;
   logic               rsp_valid_ff,   rsp_valid_in;

   logic [15:0]       val_rd;
   logic [LINK_W-1:0] link_rd;
   logic [SLOT_W-1:0] link_next;
   logic              link_end;
   logic              link_wr_en;
   logic [SLOT_W-1:0] link_wr_addr;
   logic [LINK_W-1:0] link_wr_data;

   assign link_next = link_rd[SLOT_W-1:0];
   assign link_end  = link_rd[SLOT_W];

   cll_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_value_ram (
      .clock   (clock),
      .wr_en   (cmd.app_node),
      .wr_addr (cnt_ff),
      .wr_data (req_ff.value),
      .rd_en   (cmd.rd_en),
      .rd_addr (cur_ff),
      .rd_data (val_rd)
   );

   cll_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cur_ff),
      .rd_data (link_rd)
   );

   always_comb begin
      link_wr_en   = 1'b0;
      link_wr_addr = cnt_ff;
      link_wr_data = {1'b1, {SLOT_W{1'b0}}};
      priority if (cmd.app_node) begin
         link_wr_en = 1'b1;
      end else if (cmd.app_link) begin
         link_wr_en   = 1'b1;
         link_wr_addr = tail_ff;
         link_wr_data = {1'b0, cnt_ff};
      end else if (cmd.del_unlink && prev_valid_ff) begin
         link_wr_en   = 1'b1;
         link_wr_addr = prev_ff;
         link_wr_data = {link_end, link_next};
      end
   end

   assign sts.mode       = req_ff.mode;
   assign sts.head_valid = head_valid_ff;
   assign sts.scan_free  = !used_ff[cnt_ff];
   assign sts.scan_done  = (cnt_ff == SLOT_W'(SLOTS - 1));
   assign sts.rd_match   = (val_rd == req_ff.value);
   assign sts.rd_end     = link_end;
   assign sts.list_last  = link_end || (nres_ff == NRES_W'(MAX_RESULTS - 1));
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      req_in         = req_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      prev_valid_in  = prev_valid_ff;
      cnt_in         = cnt_ff;
      nres_in        = nres_ff;
      head_in        = head_ff;
      head_valid_in  = head_valid_ff;
      tail_in        = tail_ff;
      used_in        = used_ff;
      pend_value_in  = pend_value_ff;
      pend_slot_in   = pend_slot_ff;
      pend_status_in = pend_status_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      if (cmd.latch_req) begin
         req_in = req_data;
      end
      if (cmd.start_list) begin
         cur_in  = head_ff;
         nres_in = '0;
      end
      if (cmd.start_scan) begin
         cnt_in = '0;
      end
      if (cmd.scan_step) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.start_del) begin
         cur_in        = head_ff;
         prev_valid_in = 1'b0;
      end
      if (cmd.del_step) begin
         prev_in       = cur_ff;
         prev_valid_in = 1'b1;
         cur_in        = link_next;
      end
      if (cmd.app_node) begin
         used_in[cnt_ff] = 1'b1;
         if (!head_valid_ff) begin
            head_in       = cnt_ff;
            head_valid_in = 1'b1;
            tail_in       = cnt_ff;
         end
      end
      if (cmd.app_link) begin
         tail_in = cnt_ff;
      end
      if (cmd.del_unlink) begin
         used_in[cur_ff] = 1'b0;
         if (!prev_valid_ff) begin
            if (link_end) begin
               head_valid_in = 1'b0;
            end else begin
               head_in = link_next;
            end
         end
         if (link_end) begin
            tail_in = prev_ff;
         end
      end
      if (cmd.set_result) begin
         pend_status_in = cmd.res_status;
         pend_value_in  = (req_ff.mode == MODE_LIST) ? 16'sd0 : req_ff.value;
         unique case (cmd.res_slot_src)
            SRC_CUR:  pend_slot_in = cur_ff;
            SRC_SCAN: pend_slot_in = cnt_ff;
            default:  pend_slot_in = '0;
         endcase
      end
      if (cmd.list_emit) begin
         rsp_in.value_out = val_rd;
         rsp_in.slot      = 4'(cur_ff);
         rsp_in.status    = STATUS_OK;
         rsp_in.last      = sts.list_last;
         rsp_valid_in     = 1'b1;
         cur_in           = link_next;
         nres_in          = nres_ff + 1'b1;
      end
      if (cmd.emit_pending) begin
         rsp_in.value_out = pend_value_ff;
         rsp_in.slot      = 4'(pend_slot_ff);
         rsp_in.status    = pend_status_ff;
         rsp_in.last      = 1'b1;
         rsp_valid_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         used_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         prev_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         used_ff       <= used_in;
         rsp_valid_ff  <= rsp_valid_in;
         prev_valid_ff <= prev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      cnt_ff         <= cnt_in;
      nres_ff        <= nres_in;
      head_ff        <= head_in;
      tail_ff        <= tail_in;
      pend_value_ff  <= pend_value_in;
      pend_slot_ff   <= pend_slot_in;
      pend_status_ff <= pend_status_in;
      rsp_ff         <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The list is empty exactly when no slot is in use.
   a_head_matches_used: assert property (@(posedge clock) disable iff (reset)
      head_valid_ff == (used_ff != '0))
      else $error("head marker disagrees with slot usage");

   a_head_used: assert property (@(posedge clock) disable iff (reset)
      head_valid_ff |-> (used_ff[head_ff] && used_ff[tail_ff]))
      else $error("head or tail names a free slot");

   a_append_free: assert property (@(posedge clock) disable iff (reset)
      cmd.app_node |-> !used_ff[cnt_ff])
      else $error("append into a slot in use");

   a_read_used: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> used_ff[cur_ff])
      else $error("walk reached a free slot");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.list_emit || cmd.emit_pending) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register loaded while still held");

endmodule
`default_nettype wire

// ----- rtl/cursor_linked_list_engine.sv -----
// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall cll_req_type {mode, value}
// rsp      out        rsp_valid/rsp_stall cll_rsp_type {value_out, slot, status, last}
//
// One command is worked on at a time; the next is taken once its last result is registered (an unused mode gives none).
// List reads each entry and then emits it, entry by entry; delete reads and checks each visited entry in turn.
// Append scans for a free slot, one slot per cycle, then writes the node and links it behind the old tail.
// Synchronous reset empties the list at once: every slot is marked free, no sweep is needed.
// A stalled result holds in the output register and the sequencer waits on it.
`default_nettype none
module cursor_linked_list_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire cll_pkg::cll_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output cll_pkg::cll_rsp_type      rsp_data
);
   import cll_pkg::*;

   cll_cmd_type cmd;
   cll_sts_type sts;

   cll_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   cll_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ----- tb/sv/cursor_linked_list_engine_checker.sv -----
`default_nettype none
module cursor_linked_list_engine_checker (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire cll_pkg::cll_req_type req_data,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire cll_pkg::cll_rsp_type rsp_data,
   output int                        fail_count,
   output int                        pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import cll_pkg::*;

   localparam logic [LINK_W-1:0] LINK_END  = '1;
   localparam logic [LINK_W-1:0] LINK_FREE = LINK_END - 1'b1;

   logic signed [15:0] node_value [SLOTS];
   logic [LINK_W-1:0]  node_link [SLOTS];
   logic [LINK_W-1:0]  head;
   cll_rsp_type        expected_q [$];
   int                 mismatches = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic logic in_table(input logic [LINK_W-1:0] x);
      return x < SLOTS;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t ns checker: %s", $time, what);
   endtask

   task automatic push_result(input logic signed [15:0] v, input logic [LINK_W-1:0] s,
                              input logic [1:0] st, input logic lst);
      cll_rsp_type r;
      r.value_out = v;
      r.slot      = s[SLOT_W-1:0];
      r.status    = st;
      r.last      = lst;
      expected_q.push_back(r);
   endtask

   task automatic clear_list();
      for (int i = 0; i < SLOTS; i++) begin
         node_link[SLOT_W'(i)] = LINK_FREE;
      end
      head = LINK_END;
      expected_q.delete();
   endtask

   task automatic predict_command(input cll_req_type cmd);
      logic [LINK_W-1:0] cur;
      logic [LINK_W-1:0] prev;
      logic [LINK_W-1:0] nx;
      logic [LINK_W-1:0] free_slot;
      logic [LINK_W-1:0] tail;
      logic              found;
      int                n;
      case (cmd.mode)
         MODE_LIST: begin
            if (!in_table(head)) begin
               push_result('0, '0, STATUS_EMPTY, 1'b1);
            end else begin
               cur = head;
               n   = 0;
               while (n < SLOTS && n < MAX_RESULTS && in_table(cur)) begin
                  push_result(node_value[cur[SLOT_W-1:0]], cur, STATUS_OK, 1'b0);
                  n++;
                  cur = node_link[cur[SLOT_W-1:0]];
               end
               expected_q[expected_q.size() - 1].last = 1'b1;
            end
         end
         MODE_APPEND: begin
            free_slot = LINK_END;
            for (int i = 0; i < SLOTS; i++) begin
               if (node_link[SLOT_W'(i)] == LINK_FREE && !in_table(free_slot)) begin
                  free_slot = LINK_W'(i);
               end
            end
            if (!in_table(free_slot)) begin
               push_result(cmd.value, '0, STATUS_FULL, 1'b1);
            end else begin
               if (!in_table(head)) begin
                  head = free_slot;
               end else begin
                  tail = head;
                  for (int i = 0; i < SLOTS; i++) begin
                     if (!in_table(node_link[tail[SLOT_W-1:0]])) break;
                     tail = node_link[tail[SLOT_W-1:0]];
                  end
                  node_link[tail[SLOT_W-1:0]] = free_slot;
               end
               node_value[free_slot[SLOT_W-1:0]] = cmd.value;
               node_link[free_slot[SLOT_W-1:0]]  = LINK_END;
               push_result(cmd.value, free_slot, STATUS_OK, 1'b1);
            end
         end
         MODE_DELETE: begin
            if (!in_table(head)) begin
               push_result(cmd.value, '0, STATUS_EMPTY, 1'b1);
            end else begin
               cur   = head;
               prev  = LINK_END;
               found = 1'b0;
               for (int i = 0; i < SLOTS && in_table(cur) && !found; i++) begin
                  if (node_value[cur[SLOT_W-1:0]] == cmd.value) begin
                     found = 1'b1;
                     nx    = node_link[cur[SLOT_W-1:0]];
                     if (in_table(prev)) begin
                        node_link[prev[SLOT_W-1:0]] = in_table(nx) ? nx : LINK_END;
                     end else begin
                        head = in_table(nx) ? nx : LINK_END;
                     end
                     node_link[cur[SLOT_W-1:0]] = LINK_FREE;
                     push_result(cmd.value, cur, STATUS_OK, 1'b1);
                  end else begin
                     prev = cur;
                     cur  = node_link[cur[SLOT_W-1:0]];
                  end
               end
               if (!found) begin
                  push_result(cmd.value, '0, STATUS_NOT_FOUND, 1'b1);
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      cll_rsp_type want;
      if (reset) begin
         clear_list();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf(
                  "result with nothing expected: value %0d slot %0d status %0d last %0d",
                  rsp_data.value_out, rsp_data.slot, rsp_data.status, rsp_data.last));
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.value_out !== want.value_out || rsp_data.slot !== want.slot ||
                   rsp_data.status !== want.status || rsp_data.last !== want.last) begin
                  report_mismatch($sformatf(
                     {"got value %0d slot %0d status %0d last %0d, ",
                      "want value %0d slot %0d status %0d last %0d"},
                     rsp_data.value_out, rsp_data.slot, rsp_data.status,
                     rsp_data.last, want.value_out, want.slot,
                     want.status, want.last));
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_command(req_data);
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_q.size();
   end

endmodule
`default_nettype wire

// ----- tb/sv/cursor_linked_list_engine_tb.sv -----
`default_nettype none
module cursor_linked_list_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cll_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   cll_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   cll_rsp_type rsp_data;
   int          fail_count;
   int          pending_count;
   logic        idle_req = 1'b0;
   logic        idle_rsp = 1'b0;

   logic signed [15:0] value_pool [8] = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1,
                                          16'sd1, 16'sd100, -16'sd100, 16'sh5555};

   cursor_linked_list_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   cursor_linked_list_engine_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (idle_rsp && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic signed [15:0] pick_value();
      if ($urandom_range(0, 3) != 0) begin
         return value_pool[3'($urandom_range(0, 7))];
      end
      return 16'($urandom);
   endfunction

   task automatic send_cmd(input logic [1:0] mode, input logic signed [15:0] value);
      if (idle_req && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data.mode  <= mode;
      req_data.value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      logic [1:0] mode;
      int         roll;
      int         grow;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_stall <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_cmd(MODE_LIST, 16'sd0);
      send_cmd(MODE_DELETE, 16'sh8000);
      send_cmd(MODE_APPEND, 16'sh8000);
      send_cmd(MODE_APPEND, 16'sh7FFF);
      send_cmd(MODE_APPEND, 16'sh0000);
      send_cmd(MODE_APPEND, -16'sd1);
      send_cmd(MODE_LIST, -16'sd1);
      send_cmd(MODE_DELETE, 16'sd1234);
      send_cmd(MODE_DELETE, 16'sh8000);
      send_cmd(MODE_DELETE, -16'sd1);
      send_cmd(MODE_LIST, 16'sh7FFF);
      send_cmd(MODE_UNUSED, 16'sh5555);
      for (int i = 0; i < SLOTS - 2; i++) begin
         send_cmd(MODE_APPEND, pick_value());
      end
      send_cmd(MODE_APPEND, 16'shAAAA);
      send_cmd(MODE_LIST, 16'sd0);
      drain();

      for (int round = 0; round < 5; round++) begin
         idle_req = (round == 0 || round == 2);
         idle_rsp = (round == 0 || round == 3);
         grow     = round % 2;
         for (int k = 0; k < 28; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
               mode = MODE_UNUSED;
            end else if (roll < 18) begin
               mode = MODE_LIST;
            end else if (roll < (grow ? 75 : 40)) begin
               mode = MODE_APPEND;
            end else begin
               mode = MODE_DELETE;
            end
            send_cmd(mode, pick_value());
         end
         drain();
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/cll_pkg.sv
rtl/cll_ram.sv
rtl/cll_ctrl.sv
rtl/cll_datapath.sv
rtl/cursor_linked_list_engine.sv
tb/sv/cursor_linked_list_engine_checker.sv
tb/sv/cursor_linked_list_engine_tb.sv
